// ----- rtl/core/tcsm_pkg.sv -----
// ----------------------------------------------------------------------------
// Tone curve spline mapper package
// Shared widths, operation and register codes, and small helper functions.
// ----------------------------------------------------------------------------
package tcsm_pkg;

	localparam int LVL_W  = 16;
	localparam int NPTS   = 16;
	localparam int NSEG   = NPTS - 1;
	localparam int IDX_W  = 4;
	localparam int CNT_W  = 5;
	localparam int FRAC_W = LVL_W + 4;
	localparam int COEF_W = FRAC_W + 5;
	localparam int WIDE_W = 42;
	localparam int MA_W   = 32;
	localparam int MB_W   = 22;
	localparam int PROD_W = MA_W + MB_W;
	localparam int DIV_NW = 37;
	localparam int DIV_DW = LVL_W + 1;

	localparam logic [LVL_W-1:0] LVL_MAX = '1;
	localparam logic signed [COEF_W-1:0] COEF_ID = COEF_W'({LVL_MAX, 4'b0000});
	localparam logic signed [WIDE_W-1:0] COEF_HI = WIDE_W'((64'sd1 <<< (COEF_W - 1)) - 1);
	localparam logic signed [WIDE_W-1:0] COEF_LO = -COEF_HI - WIDE_W'(1);

	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_REBUILD = 2'd1;
	localparam logic [1:0] OP_MAP     = 2'd2;

	localparam logic CFG_POINT_COUNT = 1'b0;
	localparam logic CFG_SMOOTH      = 1'b1;

	function automatic logic [CNT_W-1:0] used_points(input logic [CNT_W-1:0] cnt);
		logic [CNT_W-1:0] n;
		n = cnt;
		if (cnt < CNT_W'(2)) begin
			n = CNT_W'(2);
		end else if (cnt > CNT_W'(NPTS)) begin
			n = CNT_W'(NPTS);
		end
		return n;
	endfunction

	function automatic logic signed [LVL_W:0] sdiff(input logic [LVL_W-1:0] a,
		input logic [LVL_W-1:0] b);
		return $signed({1'b0, a}) - $signed({1'b0, b});
	endfunction

	function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [WIDE_W-1:0] v);
		logic signed [COEF_W-1:0] r;
		r = v[COEF_W-1:0];
		if (v > COEF_HI) begin
			r = COEF_HI[COEF_W-1:0];
		end else if (v < COEF_LO) begin
			r = COEF_LO[COEF_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [LVL_W-1:0] clamp_lvl(input logic signed [WIDE_W-1:0] v);
		logic [LVL_W-1:0] r;
		r = v[LVL_W-1:0];
		if (v < 0) begin
			r = '0;
		end else if (v > $signed(WIDE_W'(LVL_MAX))) begin
			r = LVL_MAX;
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/tcsm_div.sv -----
// ----------------------------------------------------------------------------
// Tone curve spline mapper divider
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcsm_div import tcsm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic              done,
	output logic [DIV_NW-1:0] quo,
	output logic              rem_nz
);

	localparam int CW = $clog2(DIV_NW + 1);

	logic              run_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DIV_NW-1:0] q_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW:0]   trial;
	logic [DIV_DW:0]   diff;
	logic              ge;

	assign trial = {rem_q, q_q[DIV_NW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DIV_NW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			q_q   <= {q_q[DIV_NW-2:0], ge};
			rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
		end
	end

	assign done   = done_q;
	assign quo    = q_q;
	assign rem_nz = rem_q != '0;

endmodule

// ----- rtl/core/tone_curve_spline_mapper_top.sv -----
// ----------------------------------------------------------------------------
// Tone curve spline mapper
// Maps pixel levels through a curve of control points, linear or cubic, with
// point writes and coefficient rebuilds run by one sequencer.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  input     start, busy          operation, point_index, point_x, point_y, pixel
//  result    done (one cycle)     mapped_value, write_rejected
//  config    cfg_we               cfg_index, cfg_data
//
// A transfer is taken when start is high and busy is low; one result follows it.
// Rebuilds and unused codes report from the idle state, writes after the index
// and lower neighbor check or, if that passes, the upper one, and maps after the
// point scan: at once at the curve ends, else after the multiplier and 37-step
// divider (linear) or the divider and Horner steps (cubic). A rebuild, or an
// accepted smooth write after its result, stays busy over every segment. Reset
// loads the identity curve. The receiver cannot stall results.
module tone_curve_spline_mapper_top import tcsm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        operation,
	input  logic [IDX_W-1:0]  point_index,
	input  logic [LVL_W-1:0]  point_x,
	input  logic [LVL_W-1:0]  point_y,
	input  logic [LVL_W-1:0]  pixel,
	output logic              done,
	output logic [LVL_W-1:0]  mapped_value,
	output logic              write_rejected,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CNT_W-1:0]  cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE, S_WPREV, S_WNEXT,
		S_RSEG, S_RRD0, S_RRD1, S_RRD2, S_RRD3, S_RMUL, S_RDIV, S_RDIVW, S_RCOEF,
		S_MSCAN, S_MDEC, S_MMUL, S_MDIV, S_MDIVW, S_HMUL, S_HADD, S_MFIN
	} state_t;

	state_t state_q;

	logic [LVL_W-1:0] px_q [NPTS];
	logic [LVL_W-1:0] py_q [NPTS];
	logic signed [COEF_W-1:0] ca_q [NSEG];
	logic signed [COEF_W-1:0] cb_q [NSEG];
	logic signed [COEF_W-1:0] cc_q [NSEG];
	logic signed [COEF_W-1:0] cd_q [NSEG];

	logic [CNT_W-1:0] cnt_q;
	logic             smooth_q;
	logic             pend_q;
	logic [CNT_W-1:0] n_q;
	logic [IDX_W-1:0] idx_q;
	logic [LVL_W-1:0] wx_q, wy_q, pix_q;
	logic [IDX_W-1:0] seg_q;
	logic [IDX_W-1:0] j_q;
	logic             tsel_q;
	logic [LVL_W-1:0] xs_q, ys_q, x0_q, y0_q, x1_q, y1_q, xe_q, ye_q;
	logic [LVL_W-1:0] yfirst_q, xl_q, yl_q;
	logic             found_q, k0_q, neg_q;
	logic signed [DIV_NW:0] t1_q, t2_q;
	logic signed [MA_W-1:0] acc_q;
	logic signed [MB_W-1:0] tq_q;
	logic [1:0]       hstep_q;
	logic             done_q, rej_q;
	logic [LVL_W-1:0] mapped_q;
	logic signed [PROD_W-1:0] prod_s1;

	logic [IDX_W-1:0] rd_addr;
	logic [LVL_W-1:0] rx, ry;
	logic             seg_last, seg_in;
	logic             rej1, rej2;
	logic             cfg_set;
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic [PROD_W-1:0] pmag;
	logic signed [LVL_W:0] dxs;
	logic [DIV_DW-1:0] dxs_mag;
	logic              div_start, div_done, div_rnz;
	logic [DIV_NW-1:0] div_num, div_quo;
	logic [DIV_DW-1:0] div_den;
	logic [LVL_W-1:0]  dk, dp;
	logic signed [DIV_NW:0] tdiv, lin_q;
	logic signed [WIDE_W-1:0] lin_r;
	logic signed [PROD_W-1:0] hsh;
	logic signed [COEF_W-1:0] hcoef;
	logic signed [MA_W-1:0] hnext;
	logic signed [MA_W-1:0] fin;
	logic signed [WIDE_W-1:0] w_y0, w_y1, w_t1, w_t2, ka, kb, kc;
	logic              coef_we;
	logic signed [COEF_W-1:0] wa, wb, wc, wd;
	logic              pt_we;

	assign busy = (state_q != S_IDLE) || pend_q;

	assign seg_last = {1'b0, seg_q} == (n_q - CNT_W'(2));
	assign seg_in   = ({1'b0, seg_q} + CNT_W'(1)) < n_q;

	always_comb begin
		case (state_q)
			S_WPREV: rd_addr = idx_q - IDX_W'(1);
			S_WNEXT: rd_addr = idx_q + IDX_W'(1);
			S_RRD0:  rd_addr = (seg_q == '0) ? seg_q : seg_q - IDX_W'(1);
			S_RRD1:  rd_addr = seg_q;
			S_RRD2:  rd_addr = seg_q + IDX_W'(1);
			S_RRD3:  rd_addr = seg_last ? seg_q + IDX_W'(1) : seg_q + IDX_W'(2);
			S_MSCAN: rd_addr = j_q;
			default: rd_addr = '0;
		endcase
	end

	assign rx = px_q[rd_addr];
	assign ry = py_q[rd_addr];

	assign rej1 = ({1'b0, idx_q} >= n_q) || ((idx_q != '0) && (rx >= wx_q));
	assign rej2 = (({1'b0, idx_q} + CNT_W'(1)) < n_q) && (wx_q >= rx);
	assign pt_we = (state_q == S_WNEXT) && !rej2;

	assign cfg_set = cfg_we && (cfg_index == CFG_SMOOTH) && !smooth_q && cfg_data[0];

	always_comb begin
		case (state_q)
			S_RMUL: begin
				mul_a = MA_W'(tsel_q ? sdiff(ye_q, y0_q) : sdiff(y1_q, ys_q));
				mul_b = MB_W'(sdiff(x1_q, x0_q));
			end
			S_MMUL: begin
				mul_a = MA_W'(sdiff(y1_q, y0_q));
				mul_b = MB_W'(sdiff(pix_q, x0_q));
			end
			S_HMUL: begin
				mul_a = acc_q;
				mul_b = tq_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign pmag    = prod_s1[PROD_W-1] ? PROD_W'(-prod_s1) : PROD_W'(prod_s1);
	assign dxs     = tsel_q ? sdiff(xe_q, x0_q) : sdiff(x1_q, xs_q);
	assign dxs_mag = dxs[LVL_W] ? DIV_DW'(-dxs) : DIV_DW'(dxs);
	assign dk      = x1_q - x0_q;
	assign dp      = pix_q - x0_q;

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (state_q)
			S_RDIV: begin
				div_start = dxs != '0;
				div_num   = {pmag[32:0], 4'b0000};
				div_den   = dxs_mag;
			end
			S_MDIV: begin
				div_start = 1'b1;
				div_num   = smooth_q ? {1'b0, dp, 20'b0} : pmag[DIV_NW-1:0];
				div_den   = {1'b0, dk};
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	tcsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem_nz (div_rnz)
	);

	assign tdiv  = neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
	assign lin_q = neg_q ? (div_rnz ? -($signed({1'b0, div_quo}) + 1) : -$signed({1'b0, div_quo}))
		: $signed({1'b0, div_quo});
	assign lin_r = WIDE_W'(lin_q) + $signed(WIDE_W'(y0_q));

	assign hsh = prod_s1 >>> FRAC_W;
	always_comb begin
		case (hstep_q)
			2'd0:    hcoef = cb_q[seg_q];
			2'd1:    hcoef = cc_q[seg_q];
			default: hcoef = cd_q[seg_q];
		endcase
	end
	assign hnext = $signed(hsh[MA_W-1:0]) + MA_W'(hcoef);
	assign fin   = (acc_q + MA_W'(8)) >>> 4;

	assign w_y0 = $signed(WIDE_W'({y0_q, 4'b0000}));
	assign w_y1 = $signed(WIDE_W'({y1_q, 4'b0000}));
	assign w_t1 = WIDE_W'(t1_q);
	assign w_t2 = WIDE_W'(t2_q);

	always_comb begin
		if ((n_q > CNT_W'(2)) && (seg_q == '0)) begin
			ka = '0;
			kb = w_t2 - w_y1 + w_y0;
			kc = w_y1 - kb - w_y0;
		end else if ((n_q > CNT_W'(2)) && seg_last) begin
			ka = '0;
			kc = w_t1;
			kb = w_y1 - kc - w_y0;
		end else begin
			kc = w_t1;
			ka = w_t2 - (w_y1 <<< 1) + kc + (w_y0 <<< 1);
			kb = w_y1 - ka - kc - w_y0;
		end
	end

	always_comb begin
		coef_we = 1'b0;
		wa = '0;
		wb = '0;
		wc = '0;
		wd = '0;
		if (state_q == S_RCOEF) begin
			coef_we = 1'b1;
			wa = sat_coef(ka);
			wb = sat_coef(kb);
			wc = sat_coef(kc);
			wd = sat_coef(w_y0);
		end else if ((state_q == S_RSEG) && !seg_in) begin
			coef_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NPTS; i++) begin
				px_q[i] <= '0;
				py_q[i] <= '0;
			end
			px_q[1] <= LVL_MAX;
			py_q[1] <= LVL_MAX;
			for (int i = 0; i < NSEG; i++) begin
				ca_q[i] <= '0;
				cb_q[i] <= '0;
				cc_q[i] <= '0;
				cd_q[i] <= '0;
			end
			cc_q[0] <= COEF_ID;
		end else begin
			if (pt_we) begin
				px_q[idx_q] <= wx_q;
				py_q[idx_q] <= wy_q;
			end
			if (coef_we) begin
				ca_q[seg_q] <= wa;
				cb_q[seg_q] <= wb;
				cc_q[seg_q] <= wc;
				cd_q[seg_q] <= wd;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= CNT_W'(2);
			smooth_q <= 1'b1;
			pend_q   <= 1'b0;
			done_q   <= 1'b0;
			rej_q    <= 1'b0;
			mapped_q <= '0;
			n_q      <= CNT_W'(2);
			idx_q    <= '0;
			wx_q     <= '0;
			wy_q     <= '0;
			pix_q    <= '0;
			seg_q    <= '0;
			j_q      <= '0;
			tsel_q   <= 1'b0;
			found_q  <= 1'b0;
			k0_q     <= 1'b0;
			neg_q    <= 1'b0;
			hstep_q  <= '0;
			xs_q     <= '0;
			ys_q     <= '0;
			x0_q     <= '0;
			y0_q     <= '0;
			x1_q     <= '0;
			y1_q     <= '0;
			xe_q     <= '0;
			ye_q     <= '0;
			yfirst_q <= '0;
			xl_q     <= '0;
			yl_q     <= '0;
			t1_q     <= '0;
			t2_q     <= '0;
			acc_q    <= '0;
			tq_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pend_q) begin
						pend_q  <= 1'b0;
						n_q     <= used_points(cnt_q);
						seg_q   <= '0;
						state_q <= S_RSEG;
					end else if (start) begin
						n_q      <= used_points(cnt_q);
						idx_q    <= point_index;
						wx_q     <= point_x;
						wy_q     <= point_y;
						pix_q    <= pixel;
						mapped_q <= '0;
						rej_q    <= 1'b0;
						case (operation)
							OP_WRITE: begin
								state_q <= S_WPREV;
							end
							OP_REBUILD: begin
								done_q  <= 1'b1;
								seg_q   <= '0;
								state_q <= S_RSEG;
							end
							OP_MAP: begin
								j_q     <= '0;
								found_q <= 1'b0;
								k0_q    <= 1'b0;
								state_q <= S_MSCAN;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_WPREV: begin
					if (rej1) begin
						done_q  <= 1'b1;
						rej_q   <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_WNEXT;
					end
				end
				S_WNEXT: begin
					done_q <= 1'b1;
					rej_q  <= rej2;
					if (!rej2 && smooth_q) begin
						seg_q   <= '0;
						state_q <= S_RSEG;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_RSEG: begin
					if (seg_in) begin
						state_q <= S_RRD0;
					end else if (seg_q == IDX_W'(NSEG - 1)) begin
						state_q <= S_IDLE;
					end else begin
						seg_q <= seg_q + IDX_W'(1);
					end
				end
				S_RRD0: begin
					xs_q    <= rx;
					ys_q    <= ry;
					state_q <= S_RRD1;
				end
				S_RRD1: begin
					x0_q    <= rx;
					y0_q    <= ry;
					state_q <= S_RRD2;
				end
				S_RRD2: begin
					x1_q    <= rx;
					y1_q    <= ry;
					state_q <= S_RRD3;
				end
				S_RRD3: begin
					xe_q    <= rx;
					ye_q    <= ry;
					tsel_q  <= 1'b0;
					state_q <= S_RMUL;
				end
				S_RMUL: begin
					state_q <= S_RDIV;
				end
				S_RDIV: begin
					neg_q <= prod_s1[PROD_W-1] ^ dxs[LVL_W];
					if (dxs != '0) begin
						state_q <= S_RDIVW;
					end else if (!tsel_q) begin
						t1_q    <= '0;
						tsel_q  <= 1'b1;
						state_q <= S_RMUL;
					end else begin
						t2_q    <= '0;
						state_q <= S_RCOEF;
					end
				end
				S_RDIVW: begin
					if (div_done) begin
						if (!tsel_q) begin
							t1_q    <= tdiv;
							tsel_q  <= 1'b1;
							state_q <= S_RMUL;
						end else begin
							t2_q    <= tdiv;
							state_q <= S_RCOEF;
						end
					end
				end
				S_RCOEF: begin
					if (seg_q == IDX_W'(NSEG - 1)) begin
						state_q <= S_IDLE;
					end else begin
						seg_q   <= seg_q + IDX_W'(1);
						state_q <= S_RSEG;
					end
				end
				S_MSCAN: begin
					if (j_q == '0) begin
						yfirst_q <= ry;
					end
					if (!found_q && (rx >= pix_q)) begin
						found_q <= 1'b1;
						k0_q    <= j_q == '0;
						seg_q   <= j_q - IDX_W'(1);
						x0_q    <= xs_q;
						y0_q    <= ys_q;
						x1_q    <= rx;
						y1_q    <= ry;
					end
					xs_q <= rx;
					ys_q <= ry;
					if ({1'b0, j_q} == (n_q - CNT_W'(1))) begin
						xl_q    <= rx;
						yl_q    <= ry;
						state_q <= S_MDEC;
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end
				S_MDEC: begin
					if (pix_q >= xl_q) begin
						mapped_q <= yl_q;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (!found_q || k0_q) begin
						mapped_q <= yfirst_q;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (smooth_q) begin
						state_q <= S_MDIV;
					end else begin
						state_q <= S_MMUL;
					end
				end
				S_MMUL: begin
					state_q <= S_MDIV;
				end
				S_MDIV: begin
					neg_q   <= !smooth_q && prod_s1[PROD_W-1];
					state_q <= S_MDIVW;
				end
				S_MDIVW: begin
					if (div_done) begin
						if (smooth_q) begin
							tq_q    <= $signed(div_quo[MB_W-1:0]);
							acc_q   <= MA_W'(ca_q[seg_q]);
							hstep_q <= '0;
							state_q <= S_HMUL;
						end else begin
							mapped_q <= clamp_lvl(lin_r);
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end
					end
				end
				S_HMUL: begin
					state_q <= S_HADD;
				end
				S_HADD: begin
					acc_q   <= hnext;
					hstep_q <= hstep_q + 2'd1;
					if (hstep_q == 2'd2) begin
						state_q <= S_MFIN;
					end else begin
						state_q <= S_HMUL;
					end
				end
				S_MFIN: begin
					mapped_q <= clamp_lvl(WIDE_W'(fin));
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg_we) begin
				case (cfg_index)
					CFG_POINT_COUNT: cnt_q <= cfg_data;
					CFG_SMOOTH: smooth_q <= cfg_data[0];
					default: cnt_q <= cnt_q;
				endcase
			end
			if (cfg_set) begin
				pend_q <= 1'b1;
			end
		end
	end

	assign done           = done_q;
	assign mapped_value   = mapped_q;
	assign write_rejected = rej_q;

endmodule
